[rtl/core/text_terminal_writer_top_macros.svh]
// Assertion macros for the text terminal writer checker.
`ifndef TEXT_TERMINAL_WRITER_TOP_MACROS_SVH
`define TEXT_TERMINAL_WRITER_TOP_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define TTW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ttw assertion failed");

// Overlapping implication on top of the above.
`define TTW_ASSERT_IMP(lbl, ante, cons) \
  `TTW_ASSERT(lbl, (ante) |-> (cons))

`endif

[rtl/core/ttw_pkg.sv]
`timescale 1ns / 1ps
package ttw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int CNT_W       = $clog2(CELLS + 1);
  localparam int CUR_W       = $clog2(CELLS + COLUMNS);
  localparam int CELL_IDX_W  = 11;
  localparam int CELL_W      = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0700;
  localparam logic [7:0]        RESET_COLOR = 8'h07;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'd27;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_READ  = 4'd0;
  localparam logic [OP_W-1:0] OP_PRINT = 4'd1;
  localparam logic [OP_W-1:0] OP_NL    = 4'd2;
  localparam logic [OP_W-1:0] OP_CR    = 4'd3;
  localparam logic [OP_W-1:0] OP_TAB   = 4'd4;
  localparam logic [OP_W-1:0] OP_VT    = 4'd5;
  localparam logic [OP_W-1:0] OP_BS    = 4'd6;
  localparam logic [OP_W-1:0] OP_FF    = 4'd7;
  localparam logic [OP_W-1:0] OP_NUL   = 4'd8;
  localparam logic [OP_W-1:0] OP_ESC   = 4'd9;

  typedef struct packed {
    logic                  action;
    logic [7:0]            char_code;
    logic                  last_of_write;
    logic [CELL_IDX_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]            read_char;
    logic [7:0]            read_attr;
    logic [CELL_IDX_W-1:0] cursor_pos;
    logic [7:0]            text_color;
  } out_item_t;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [7:0]            code;
    logic                  last;
    logic [CELL_IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/core/text_terminal_writer_top.sv]
// Items enter a two-entry queue, so new ones are taken while the sequencer serves the last; a put
//   runs EXEC then OUT, a read EXEC, READ, OUT, and last_of_write adds the cell recolour (FL_RD, FL_WR).
// A scroll walks the RAM one cell a cycle, copying rows up and then blanking the last row; form
//   feed blanks every cell and returns the cursor to the first cell.
// Reset: synchronous; afterwards a blanking pass over every cell holds in_ready low.
`timescale 1ns / 1ps
module text_terminal_writer_top import ttw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  q_status_t qs;
  logic      busy;
  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      pop_cmd;

  ttw_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .busy     (busy),
    .qs       (qs),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ttw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .qs       (qs)
  );

  ttw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qs        (qs),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

[rtl/core/ttw_front.sv]
`timescale 1ns / 1ps
module ttw_front import ttw_pkg::*; (
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  input  logic      busy,
  input  q_status_t qs,
  output logic      push,
  output cmd_t      push_cmd
);

  logic [OP_W-1:0] op;

  always_comb begin
    case (in_item.char_code)
      CH_ESC:  op = OP_ESC;
      CH_NL:   op = OP_NL;
      CH_BS:   op = OP_BS;
      CH_CR:   op = OP_CR;
      CH_NUL:  op = OP_NUL;
      CH_TAB:  op = OP_TAB;
      CH_VT:   op = OP_VT;
      CH_FF:   op = OP_FF;
      default: op = OP_PRINT;
    endcase
    if (in_item.action) begin
      op = OP_READ;
    end
  end

  assign in_ready = !qs.full && !busy;
  assign push     = in_valid && in_ready;

  assign push_cmd.op   = op;
  assign push_cmd.code = in_item.char_code;
  assign push_cmd.last = in_item.last_of_write;
  assign push_cmd.idx  = in_item.cell_index;

endmodule

[rtl/core/ttw_queue.sv]
`timescale 1ns / 1ps
module ttw_queue import ttw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      pop_cmd,
  output q_status_t qs
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign qs.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qs.empty = (count == '0);
  assign pop_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

[rtl/core/ttw_back.sv]
`timescale 1ns / 1ps
module ttw_back import ttw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_status_t qs,
  input  cmd_t      pop_cmd,
  output logic      pop,
  output logic      busy,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_EXEC  = 4'd2;
  localparam logic [3:0] ST_READ  = 4'd3;
  localparam logic [3:0] ST_COPY  = 4'd4;
  localparam logic [3:0] ST_FILL  = 4'd5;
  localparam logic [3:0] ST_FL_RD = 4'd6;
  localparam logic [3:0] ST_FL_WR = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  localparam logic [CUR_W-1:0] C_COLS  = CUR_W'(COLUMNS);
  localparam logic [CUR_W-1:0] C_CELLS = CUR_W'(CELLS);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  logic [3:0]       state;
  logic [CNT_W-1:0] cnt;
  cmd_t             cmd;
  logic [CUR_W-1:0] cursor;
  logic [CUR_W-1:0] row_base;
  logic [7:0]       color;
  logic             esc;
  logic             rd_ok;
  logic [7:0]       res_char;
  logic [7:0]       res_attr;

  logic [CUR_W-1:0] cursor_next;
  logic [CUR_W-1:0] row_base_next;
  logic [CUR_W-1:0] row_end;
  logic [CUR_W-1:0] tab_pos;
  logic             out_load;
  logic [3:0]       after_put;

  assign busy      = (state == ST_INIT);
  assign pop       = (state == ST_IDLE) && !qs.empty;
  assign out_load  = (state == ST_OUT) && (!out_valid || out_ready);
  assign after_put = cmd.last ? ST_FL_RD : ST_OUT;
  assign row_end   = row_base + C_COLS;
  assign tab_pos   = {cursor[CUR_W-1:3], 3'b000} + CUR_W'(8);

  always_comb begin
    cursor_next   = cursor;
    row_base_next = row_base;
    case (cmd.op)
      OP_PRINT: begin
        cursor_next = cursor + CUR_W'(1);
        if (cursor_next == row_end) begin
          row_base_next = row_end;
        end
      end
      OP_NL: begin
        cursor_next   = row_end;
        row_base_next = row_end;
      end
      OP_CR: cursor_next = row_base;
      OP_TAB: begin
        cursor_next = tab_pos;
        if (tab_pos >= row_end) begin
          row_base_next = row_end;
        end
      end
      OP_VT: begin
        cursor_next   = cursor + C_COLS;
        row_base_next = row_end;
      end
      OP_BS: begin
        if (cursor != '0) begin
          cursor_next = cursor - CUR_W'(1);
          if (cursor == row_base) begin
            row_base_next = row_base - C_COLS;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ADDR_W'(cursor);
    mem_wdata = BLANK_CELL;
    mem_raddr = ADDR_W'(cursor);
    case (state)
      ST_INIT, ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(cnt);
      end
      ST_EXEC: begin
        mem_raddr = ADDR_W'(cmd.idx);
        if (!esc && cmd.op == OP_PRINT) begin
          mem_we    = 1'b1;
          mem_wdata = {color, cmd.code};
        end else if (!esc && cmd.op == OP_BS) begin
          mem_we    = 1'b1;
          mem_wdata = '0;
        end
      end
      ST_COPY: begin
        mem_raddr = ADDR_W'(cnt + CNT_W'(COLUMNS));
        mem_we    = (cnt != '0);
        mem_waddr = ADDR_W'(cnt - CNT_W'(1));
        mem_wdata = rd_data;
      end
      ST_FL_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {color, rd_data[7:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= pop_cmd;
    end
    if (out_load) begin
      out_item.read_char  <= res_char;
      out_item.read_attr  <= res_attr;
      out_item.cursor_pos <= CELL_IDX_W'(cursor);
      out_item.text_color <= color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      cursor    <= '0;
      row_base  <= '0;
      color     <= RESET_COLOR;
      esc       <= 1'b0;
      out_valid <= 1'b0;
      rd_ok     <= 1'b0;
      res_char  <= '0;
      res_attr  <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          if (cnt == CNT_W'(CELLS - 1)) begin
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_IDLE: begin
          if (pop) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_char <= '0;
          res_attr <= '0;
          if (cmd.op == OP_READ) begin
            rd_ok <= (32'(cmd.idx) < CELLS);
            state <= ST_READ;
          end else if (esc) begin
            color <= cmd.code;
            esc   <= 1'b0;
            state <= after_put;
          end else if (cmd.op == OP_ESC) begin
            esc   <= 1'b1;
            state <= after_put;
          end else if (cmd.op == OP_FF) begin
            cursor   <= '0;
            row_base <= '0;
            cnt      <= '0;
            state    <= ST_FILL;
          end else if (cursor_next >= C_CELLS) begin
            cursor   <= cursor_next - C_COLS;
            row_base <= row_base_next - C_COLS;
            cnt      <= '0;
            state    <= ST_COPY;
          end else begin
            cursor   <= cursor_next;
            row_base <= row_base_next;
            state    <= after_put;
          end
        end
        ST_READ: begin
          res_char <= rd_ok ? rd_data[7:0] : 8'h00;
          res_attr <= rd_ok ? rd_data[15:8] : 8'h00;
          state    <= ST_OUT;
        end
        ST_COPY: begin
          if (cnt == CNT_W'(CELLS - COLUMNS)) begin
            state <= ST_FILL;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_FILL: begin
          if (cnt == CNT_W'(CELLS - 1)) begin
            state <= after_put;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_FL_RD: state <= ST_FL_WR;
        ST_FL_WR: state <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/ttw_checker.sv]
`timescale 1ns / 1ps
`include "text_terminal_writer_top_macros.svh"
module ttw_checker import ttw_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  `TTW_ASSERT_IMP(a_in_hold, in_valid && !in_ready, ##1 (in_valid && $stable(in_item)))
  `TTW_ASSERT_IMP(a_out_hold, out_valid && !out_ready, ##1 (out_valid && $stable(out_item)))
  `TTW_ASSERT_IMP(a_cursor_range, out_valid, out_item.cursor_pos < CELL_IDX_W'(CELLS))
  `TTW_ASSERT_IMP(a_blank_after_reset, $past(rst), !in_ready && !out_valid)

endmodule

bind text_terminal_writer_top ttw_checker u_ttw_checker (.*);

[sim/ttw_checker.sv]
`timescale 1ns / 1ps
module tb_checker import ttw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  localparam logic ACT_READ = 1'b1;

  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cursor;
  logic [7:0]        colour;
  bit                esc_seen;
  out_item_t         expected_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic blank_range(input int from, input int count);
    for (int k = from; k < from + count; k++) screen[k] = BLANK_CELL;
  endtask

  task automatic put_byte(input logic [7:0] c);
    if (esc_seen) begin
      colour   = c;
      esc_seen = 1'b0;
      return;
    end
    case (c)
      CH_ESC: begin
        esc_seen = 1'b1;
        return;
      end
      CH_NL:  cursor = (cursor / COLUMNS + 1) * COLUMNS;
      CH_BS: begin
        if (cursor < CELLS) screen[cursor] = '0;
        if (cursor > 0) cursor--;
      end
      CH_CR:  cursor = cursor / COLUMNS * COLUMNS;
      CH_NUL: ;
      CH_TAB: cursor = (cursor & ~32'd7) + 8;
      CH_VT:  cursor += COLUMNS;
      CH_FF: begin
        blank_range(0, CELLS);
        cursor = 0;
      end
      default: begin
        if (cursor < CELLS) screen[cursor] = {colour, c};
        cursor++;
      end
    endcase
    // scroll up a row at a time until the cursor is back on screen
    while (cursor >= CELLS) begin
      for (int k = 0; k < CELLS - COLUMNS; k++) screen[k] = screen[k + COLUMNS];
      blank_range(CELLS - COLUMNS, COLUMNS);
      cursor -= COLUMNS;
    end
  endtask

  task automatic terminal_step(input in_item_t it, output out_item_t res);
    res = '0;
    if (it.action == ACT_READ) begin
      if (it.cell_index < CELLS) begin
        res.read_char = screen[it.cell_index][7:0];
        res.read_attr = screen[it.cell_index][15:8];
      end
    end else begin
      put_byte(it.char_code);
      // cursor flush on the final byte of a write
      if (it.last_of_write && cursor < CELLS) screen[cursor][15:8] = colour;
    end
    res.cursor_pos = cursor[CELL_IDX_W-1:0];
    res.text_color = colour;
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      blank_range(0, CELLS);
      cursor   = 0;
      colour   = RESET_COLOR;
      esc_seen = 1'b0;
      expected_q.delete();
      pending  = 0;
    end else begin
      if (in_valid && in_ready) begin
        terminal_step(in_item, want);
        expected_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected item char %02h attr %02h cur %0d col %02h", $time,
                     out_item.read_char, out_item.read_attr, out_item.cursor_pos,
                     out_item.text_color);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_item.read_char !== want.read_char || out_item.read_attr !== want.read_attr ||
              out_item.cursor_pos !== want.cursor_pos ||
              out_item.text_color !== want.text_color) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp char %02h attr %02h cur %0d col %02h,", $time,
                       want.read_char, want.read_attr, want.cursor_pos, want.text_color,
                       " got char %02h attr %02h cur %0d col %02h",
                       out_item.read_char, out_item.read_attr, out_item.cursor_pos,
                       out_item.text_color);
            fail_count++;
          end
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import ttw_pkg::*;

  localparam logic ACT_PUT     = 1'b0;
  localparam logic ACT_READ    = 1'b1;
  localparam int   N_DIRECTED  = 25;
  localparam int   N_RANDOM    = 750;
  localparam int   HOLD_CYCLES = 400;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  bit        no_idle   = 1'b0;
  bit        hold_req  = 1'b0;
  bit        hold_done = 1'b0;
  int        n_sent    = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  text_terminal_writer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  tb_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic in_item_t put_item(input logic [7:0] c, input logic last);
    in_item_t it;
    it.action        = ACT_PUT;
    it.char_code     = c;
    it.last_of_write = last;
    it.cell_index    = CELL_IDX_W'($urandom_range(2047));
    return it;
  endfunction

  function automatic in_item_t read_item(input logic [CELL_IDX_W-1:0] idx);
    in_item_t it;
    it.action        = ACT_READ;
    it.char_code     = 8'($urandom_range(255));
    it.last_of_write = 1'($urandom_range(1));
    it.cell_index    = idx;
    return it;
  endfunction

  task automatic send(input in_item_t it);
    while (!no_idle && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // receiver: random stalls, plus one long hold-off to back the block up
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin
    #100_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int         r;
    int         burst;
    logic [7:0] c;
    logic [7:0] ctl;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send(read_item(11'd0));
    send(read_item(11'h7FF));
    send(put_item(8'h41, 1'b0));
    send(put_item(8'hFF, 1'b1));
    send(put_item(CH_ESC, 1'b0));
    send(put_item(8'h1E, 1'b0));
    send(put_item(8'h42, 1'b1));
    send(put_item(CH_ESC, 1'b0));
    send(put_item(CH_ESC, 1'b0));
    send(put_item(CH_TAB, 1'b0));
    send(put_item(CH_NL, 1'b1));
    send(put_item(CH_VT, 1'b0));
    send(put_item(CH_CR, 1'b0));
    send(put_item(CH_BS, 1'b0));
    send(put_item(CH_NUL, 1'b1));
    send(read_item(11'd0));
    send(read_item(11'd1999));
    send(put_item(CH_FF, 1'b0));
    send(put_item(CH_BS, 1'b1));
    send(put_item(8'h01, 1'b0));
    send(put_item(CH_ESC, 1'b0));
    send(put_item(CH_NUL, 1'b1));
    send(put_item(8'h80, 1'b1));
    send(put_item(CH_ESC, 1'b0));
    send(put_item(RESET_COLOR, 1'b0));

    while (n_sent < N_DIRECTED + N_RANDOM) begin
      no_idle = (n_sent > 300 && n_sent < 420);
      if (n_sent > 520) hold_req = 1'b1;
      r = $urandom_range(99);
      if (r < 22) begin
        if ($urandom_range(9) == 0)
          send(read_item(CELL_IDX_W'($urandom_range(2047, CELLS))));
        else
          send(read_item(CELL_IDX_W'($urandom_range(CELLS - 1))));
      end else if (r < 25) begin
        send(put_item(CH_ESC, 1'b0));
        send(put_item(8'($urandom_range(255)), 1'($urandom_range(3) == 0)));
      end else if (r < 31) begin
        send(put_item(CH_NL, 1'($urandom_range(3) == 0)));
      end else if (r < 36) begin
        send(put_item(CH_VT, 1'($urandom_range(3) == 0)));
      end else if (r < 39) begin
        send(put_item(CH_TAB, 1'($urandom_range(3) == 0)));
      end else if (r < 42) begin
        send(put_item(CH_CR, 1'($urandom_range(3) == 0)));
      end else if (r < 46) begin
        send(put_item(CH_BS, 1'($urandom_range(3) == 0)));
      end else if (r < 48) begin
        send(put_item(CH_NUL, 1'($urandom_range(3) == 0)));
      end else if (r < 49 && $urandom_range(1) == 0) begin
        send(put_item(CH_FF, 1'($urandom_range(3) == 0)));
      end else if (r == 49) begin
        // run of line moves to reach the bottom and scroll
        burst = $urandom_range(25, 5);
        for (int k = 0; k < burst; k++) begin
          ctl = ($urandom_range(1) == 0) ? CH_NL : CH_VT;
          send(put_item(ctl, 1'($urandom_range(3) == 0)));
        end
      end else begin
        c = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(126, 32));
        send(put_item(c, 1'($urandom_range(3) == 0)));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
